[rtl/core/ps2_device_command_ack_retry_defines.svh]
// ---------------------------------------------------------------------------
// ps2_device_command_ack_retry_defines.svh
// Assertion macros for the checker file of the PS/2 sender.
// ---------------------------------------------------------------------------
`ifndef PS2_DEVICE_COMMAND_ACK_RETRY_DEFINES_SVH
`define PS2_DEVICE_COMMAND_ACK_RETRY_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PS2DCA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define PS2DCA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ps2dca_pkg.sv]
// ---------------------------------------------------------------------------
// ps2dca_pkg
// Types, codes and constants of the PS/2 device command sender.
// ---------------------------------------------------------------------------
package ps2dca_pkg;

    // Request codes
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_REPLY   = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EIO     = 2'd1;
    localparam logic [1:0] ST_GAVE_UP = 2'd2;

    // Protocol bytes
    localparam logic [7:0] CMD_PORT2    = 8'hD4;
    localparam logic [7:0] REPLY_BAT    = 8'hAA;
    localparam logic [7:0] REPLY_ACK    = 8'hFA;
    localparam logic [7:0] REPLY_RESEND = 8'hFE;

    // Configuration port
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 4;
    localparam logic [0:0] CFG_MAX_ATTEMPTS = 1'd0;
    localparam logic [0:0] CFG_MAX_READS    = 1'd1;
    localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd10;
    localparam logic [1:0] MAX_READS_RST    = 2'd3;
    localparam logic [3:0] ATTEMPT_SAT      = 4'd15;

    // Result store depth
    localparam int OUTQ_DEPTH = 4;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       port2;
        logic [7:0] reply_byte;
    } req_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } rsp_t;

    // Results of one decided request, toward the result store
    typedef struct packed {
        logic [1:0] cnt;
        rsp_t       res0;
        rsp_t       res1;
    } push_t;

endpackage

[rtl/core/ps2dca_outq.sv]
// ---------------------------------------------------------------------------
// ps2dca_outq
// Result store: takes up to two words a cycle, hands out one word a cycle while rsp_ready is high.
// ---------------------------------------------------------------------------
module ps2dca_outq #(
    parameter int DEPTH = ps2dca_pkg::OUTQ_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ps2dca_pkg::push_t   push,
    output logic                room,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ps2dca_pkg::rsp_t    rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

    ps2dca_pkg::rsp_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_2nd;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign room      = (count_reg <= ROOM_MAX);
    assign rsp_valid = (count_reg != '0);
    assign rsp       = mem[rd_ptr_reg];
    assign pop       = rsp_valid && rsp_ready;
    assign wr_ptr_2nd = ptr_inc(wr_ptr_reg);

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_2nd;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_2nd);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write incoming words
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2)
        begin
            mem[wr_ptr_2nd] <= push.res1;
        end
    end

endmodule

[rtl/core/ps2dca_engine.sv]
// ---------------------------------------------------------------------------
// ps2dca_engine
// Request register, send state and the per-request decision logic.
// ---------------------------------------------------------------------------
module ps2dca_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  ps2dca_pkg::req_t   req,
    input  logic [3:0]         max_attempts,
    input  logic [1:0]         max_reads,
    input  logic               room,
    output ps2dca_pkg::push_t  push
);

    logic             in_valid_reg, in_valid_next;
    ps2dca_pkg::req_t item_reg;
    logic             busy_reg, busy_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_port_reg, held_port_next;
    logic [3:0]       attempt_reg, attempt_next;
    logic [1:0]       read_reg, read_next;
    logic             fire;
    logic             take;

    assign fire      = in_valid_reg && room;
    assign req_ready = !in_valid_reg || room;
    assign take      = req_valid && req_ready;

    // Hold the request until the decision stage takes it
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    // Decide results and next send state
    always_comb
    begin
        logic [1:0] rc;
        logic [3:0] ac;
        logic [7:0] send_byte;
        logic       send_port;
        logic       do_send;
        logic       do_finish;
        logic [1:0] fin_st;

        rc        = read_reg + 2'd1;
        ac        = (attempt_reg < ps2dca_pkg::ATTEMPT_SAT) ? attempt_reg + 4'd1 : attempt_reg;
        send_byte = held_byte_reg;
        send_port = held_port_reg;
        do_send   = 1'b0;
        do_finish = 1'b0;
        fin_st    = ps2dca_pkg::ST_OK;

        busy_next      = busy_reg;
        held_byte_next = held_byte_reg;
        held_port_next = held_port_reg;
        attempt_next   = attempt_reg;
        read_next      = read_reg;

        if (fire)
        begin
            case (item_reg.req_type)
                ps2dca_pkg::REQ_START:
                begin
                    if (!busy_reg)
                    begin
                        busy_next      = 1'b1;
                        held_byte_next = item_reg.data_byte;
                        held_port_next = item_reg.port2;
                        attempt_next   = 4'd0;
                        send_byte      = item_reg.data_byte;
                        send_port      = item_reg.port2;
                        do_send        = 1'b1;
                    end
                end
                ps2dca_pkg::REQ_TIMEOUT:
                begin
                    if (busy_reg)
                    begin
                        do_finish = 1'b1;
                        fin_st    = ps2dca_pkg::ST_EIO;
                    end
                end
                ps2dca_pkg::REQ_REPLY:
                begin
                    if (busy_reg)
                    begin
                        case (item_reg.reply_byte)
                            ps2dca_pkg::REPLY_BAT:
                            begin
                                read_next = rc;
                                if (rc >= max_reads || rc == 2'd0)
                                begin
                                    do_finish = 1'b1;
                                    fin_st    = ps2dca_pkg::ST_EIO;
                                end
                            end
                            ps2dca_pkg::REPLY_ACK:
                            begin
                                do_finish = 1'b1;
                                fin_st    = ps2dca_pkg::ST_OK;
                            end
                            ps2dca_pkg::REPLY_RESEND:
                            begin
                                attempt_next = ac;
                                if (ac >= max_attempts)
                                begin
                                    do_finish = 1'b1;
                                    fin_st    = ps2dca_pkg::ST_GAVE_UP;
                                end
                                else
                                begin
                                    do_send = 1'b1;
                                end
                            end
                            default:
                            begin
                                do_finish = 1'b1;
                                fin_st    = ps2dca_pkg::ST_EIO;
                            end
                        endcase
                    end
                end
                default:
                begin
                    do_send = 1'b0;
                end
            endcase
        end

        // Drop busy on completion, restart the read count on each send
        if (do_finish)
            busy_next = 1'b0;
        if (do_send)
            read_next = 2'd0;

        push.cnt  = 2'd0;
        push.res0 = '0;
        push.res1 = '0;
        if (do_finish)
        begin
            push.cnt           = 2'd1;
            push.res0.out_kind = ps2dca_pkg::KIND_DONE;
            push.res0.status   = fin_st;
            push.res0.last     = 1'b1;
        end
        else if (do_send && send_port)
        begin
            push.cnt           = 2'd2;
            push.res0.out_kind = ps2dca_pkg::KIND_CMD;
            push.res0.out_byte = ps2dca_pkg::CMD_PORT2;
            push.res1.out_kind = ps2dca_pkg::KIND_DATA;
            push.res1.out_byte = send_byte;
            push.res1.last     = 1'b1;
        end
        else if (do_send)
        begin
            push.cnt           = 2'd1;
            push.res0.out_kind = ps2dca_pkg::KIND_DATA;
            push.res0.out_byte = send_byte;
            push.res0.last     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            busy_reg      <= 1'b0;
            held_byte_reg <= 8'd0;
            held_port_reg <= 1'b0;
            attempt_reg   <= 4'd0;
            read_reg      <= 2'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            busy_reg      <= busy_next;
            held_byte_reg <= held_byte_next;
            held_port_reg <= held_port_next;
            attempt_reg   <= attempt_next;
            read_reg      <= read_next;
        end
    end

    // Load the request word
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= req;
    end

endmodule

[rtl/core/ps2_device_command_ack_retry.sv]
// ---------------------------------------------------------------------------
// ps2_device_command_ack_retry
// Host-side PS/2 device byte sender with acknowledge and resend handling.
//
//   channel  dir  handshake            word
//   req      in   req_valid/req_ready  ps2dca_pkg::req_t
//   rsp      out  rsp_valid/rsp_ready  ps2dca_pkg::rsp_t
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// A request word is decided from the request register once the result store
// has room for two words, and its result words join the store at the next
// edge. One request enters per cycle while the result store has that room;
// the single result port drains one word a cycle while rsp_ready is high,
// and a request causes at most two words, a command and a data word.
// Reset clears all control state and loads max_attempts 10, max_reads 3.
// Stalls on rsp back up through the result store into req_ready.
// ---------------------------------------------------------------------------
module ps2_device_command_ack_retry #(
    parameter int OUTQ_DEPTH = ps2dca_pkg::OUTQ_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  ps2dca_pkg::req_t                     req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output ps2dca_pkg::rsp_t                     rsp,
    input  logic                                 cfg_we,
    input  logic [ps2dca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ps2dca_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [3:0]        max_attempts_reg;
    logic [1:0]        max_reads_reg;
    logic              room;
    ps2dca_pkg::push_t push;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_attempts_reg <= ps2dca_pkg::MAX_ATTEMPTS_RST;
            max_reads_reg    <= ps2dca_pkg::MAX_READS_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == ps2dca_pkg::CFG_MAX_ATTEMPTS)
                max_attempts_reg <= cfg_wdata[3:0];
            if (cfg_index == ps2dca_pkg::CFG_MAX_READS)
                max_reads_reg <= cfg_wdata[1:0];
        end
    end

    ps2dca_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .max_attempts (max_attempts_reg),
        .max_reads    (max_reads_reg),
        .room         (room),
        .push         (push)
    );

    ps2dca_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[rtl/core/ps2dca_checker.sv]
// ---------------------------------------------------------------------------
// ps2dca_checker
// Port-level checks on the result channel of the PS/2 sender.
// ---------------------------------------------------------------------------
`include "ps2_device_command_ack_retry_defines.svh"

module ps2dca_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  ps2dca_pkg::rsp_t  rsp
);

    // Hold a stalled result word
    `PS2DCA_ASSERT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "rsp word changed while stalled")

    // Completion closes the request and carries no byte
    `PS2DCA_ASSERT(a_done_last, clk, rst_n, rsp_valid && rsp.out_kind == ps2dca_pkg::KIND_DONE |-> rsp.last && rsp.out_byte == 8'd0, "completion word malformed")

    // Port select command is 0xD4 and is not the last word
    `PS2DCA_ASSERT(a_cmd_d4, clk, rst_n, rsp_valid && rsp.out_kind == ps2dca_pkg::KIND_CMD |-> !rsp.last && rsp.out_byte == ps2dca_pkg::CMD_PORT2, "command word malformed")

    // Write words carry no status
    `PS2DCA_ASSERT(a_write_status, clk, rst_n, rsp_valid && rsp.out_kind != ps2dca_pkg::KIND_DONE |-> rsp.status == ps2dca_pkg::ST_OK && (rsp.out_kind == ps2dca_pkg::KIND_CMD || rsp.out_kind == ps2dca_pkg::KIND_DATA), "write word malformed")

endmodule

bind ps2_device_command_ack_retry ps2dca_checker u_ps2dca_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
